// ----- src/sha1md_pkg.sv -----
// sha1md_pkg: shared types and constants of the sha-1 message digest block
// used by the controller, the datapath and the top level; depends on nothing

package sha1md_pkg;

   localparam logic [1:0] CMD_APPEND        = 2'd0;
   localparam logic [1:0] CMD_APPEND_FINISH = 2'd1;
   localparam logic [1:0] CMD_FINISH        = 2'd2;

   localparam int unsigned HASH_WORDS = 5;
   localparam int unsigned ROUNDS     = 80;

   localparam logic [2:0] LAST_WORD_IDX = 3'(HASH_WORDS - 1);
   localparam logic [6:0] LAST_ROUND    = 7'(ROUNDS - 1);

   localparam logic [5:0] LAST_POS = 6'h3F;
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [31:0] INIT_H0 = 32'h67452301;
   localparam logic [31:0] INIT_H1 = 32'hEFCDAB89;
   localparam logic [31:0] INIT_H2 = 32'h98BADCFE;
   localparam logic [31:0] INIT_H3 = 32'h10325476;
   localparam logic [31:0] INIT_H4 = 32'hC3D2E1F0;

   localparam logic [31:0] K_0 = 32'h5A827999;
   localparam logic [31:0] K_1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_3 = 32'hCA62C1D6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_ROUND,
      ST_FINAL,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      SRC_MSG,
      SRC_MARK,
      SRC_ZERO,
      SRC_LEN
   } byte_src_type;

   typedef struct packed {
      logic         load_byte;
      byte_src_type src;
      logic         count_inc;
      logic         round_load;
      logic         round;
      logic [6:0]   round_idx;
      logic         final_add;
      logic         restart;
      logic [2:0]   out_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic pos_last;
      logic pos_at_len;
   } dp_sts_type;

endpackage

// ----- src/sha1md_if.sv -----
// sha1md_if: valid/ready channel interfaces of the sha-1 message digest block
// request channel carries command and byte, response channel the digest words

interface sha1md_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] data_byte;

   modport source (output valid, cmd, data_byte, input ready);
   modport sink   (input valid, cmd, data_byte, output ready);
endinterface

interface sha1md_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- src/sha1md_datapath.sv -----
// sha1md_datapath: block shift register, byte counters, round registers and
// chaining value of the sha-1 engine; depends on sha1md_pkg

module sha1md_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             data_byte,
   input  sha1md_pkg::dp_cmd_type dp_cmd,
   output sha1md_pkg::dp_sts_type dp_sts,
   output logic [31:0]            digest_word
);
   import sha1md_pkg::*;

   logic [511:0] blk_ff, blk_in;
   logic [5:0]   pos_ff, pos_in;
   logic [63:0]  count_ff, count_in;
   logic [31:0]  hash_ff [HASH_WORDS];
   logic [31:0]  hash_in [HASH_WORDS];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;

   logic [7:0]   byte_val;
   logic [63:0]  len_shift;
   logic [31:0]  w0, w2, w8, w13, w_mix, w_next;
   logic [31:0]  f_val, k_val, temp;

   assign w0  = blk_ff[511:480];
   assign w2  = blk_ff[447:416];
   assign w8  = blk_ff[255:224];
   assign w13 = blk_ff[95:64];
   assign w_mix  = w13 ^ w8 ^ w2 ^ w0;
   assign w_next = {w_mix[30:0], w_mix[31]};

   assign len_shift = count_ff >> {~pos_ff[2:0], 3'b000};

   always_comb begin
      case (dp_cmd.src)
         SRC_MSG:  byte_val = data_byte;
         SRC_MARK: byte_val = PAD_MARK;
         SRC_ZERO: byte_val = 8'h00;
         SRC_LEN:  byte_val = len_shift[7:0];
         default:  byte_val = 8'h00;
      endcase
   end

   always_comb begin
      if (dp_cmd.round_idx inside {[7'd0:7'd19]}) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K_0;
      end else if (dp_cmd.round_idx inside {[7'd20:7'd39]}) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_1;
      end else if (dp_cmd.round_idx inside {[7'd40:7'd59]}) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K_2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_3;
      end
   end

   assign temp = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w0;

   always_comb begin
      blk_in   = blk_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      for (int i = 0; i < HASH_WORDS; i++) begin
         hash_in[i] = hash_ff[i];
      end

      if (dp_cmd.load_byte) begin
         blk_in = {blk_ff[503:0], byte_val};
         pos_in = pos_ff + 6'd1;
      end
      if (dp_cmd.count_inc) begin
         count_in = count_ff + 64'd8;
      end
      if (dp_cmd.round_load) begin
         a_in = hash_ff[0];
         b_in = hash_ff[1];
         c_in = hash_ff[2];
         d_in = hash_ff[3];
         e_in = hash_ff[4];
      end
      if (dp_cmd.round) begin
         blk_in = {blk_ff[479:0], w_next};
         a_in = temp;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
      if (dp_cmd.final_add) begin
         hash_in[0] = hash_ff[0] + a_ff;
         hash_in[1] = hash_ff[1] + b_ff;
         hash_in[2] = hash_ff[2] + c_ff;
         hash_in[3] = hash_ff[3] + d_ff;
         hash_in[4] = hash_ff[4] + e_ff;
      end
      if (dp_cmd.restart) begin
         hash_in[0] = INIT_H0;
         hash_in[1] = INIT_H1;
         hash_in[2] = INIT_H2;
         hash_in[3] = INIT_H3;
         hash_in[4] = INIT_H4;
         count_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         count_ff   <= '0;
         hash_ff[0] <= INIT_H0;
         hash_ff[1] <= INIT_H1;
         hash_ff[2] <= INIT_H2;
         hash_ff[3] <= INIT_H3;
         hash_ff[4] <= INIT_H4;
      end else begin
         pos_ff   <= pos_in;
         count_ff <= count_in;
         for (int i = 0; i < HASH_WORDS; i++) begin
            hash_ff[i] <= hash_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
   end

   always_comb begin
      case (dp_cmd.out_idx)
         3'd0:    digest_word = hash_ff[0];
         3'd1:    digest_word = hash_ff[1];
         3'd2:    digest_word = hash_ff[2];
         3'd3:    digest_word = hash_ff[3];
         default: digest_word = hash_ff[4];
      endcase
   end

   assign dp_sts.pos_last   = (pos_ff == LAST_POS);
   assign dp_sts.pos_at_len = (pos_ff == LEN_POS);

endmodule

// ----- src/sha1md_ctrl.sv -----
// sha1md_ctrl: sequencing state machine for byte loading, padding, rounds
// and digest output; depends on sha1md_pkg

module sha1md_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_cmd,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sha1md_pkg::dp_cmd_type dp_cmd,
   input  sha1md_pkg::dp_sts_type dp_sts
);
   import sha1md_pkg::*;

   state_type  state_ff, state_in;
   state_type  ret_ff, ret_in;
   logic [6:0] round_ff, round_in;
   logic [2:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         round_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      round_in  = round_ff;
      idx_in    = idx_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      dp_cmd            = '0;
      dp_cmd.src        = SRC_MSG;
      dp_cmd.round_idx  = round_ff;
      dp_cmd.out_idx    = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == CMD_APPEND || req_cmd == CMD_APPEND_FINISH) begin
                  dp_cmd.load_byte = 1'b1;
                  dp_cmd.src       = SRC_MSG;
                  dp_cmd.count_inc = 1'b1;
                  if (dp_sts.pos_last) begin
                     dp_cmd.round_load = 1'b1;
                     round_in = '0;
                     state_in = ST_ROUND;
                     ret_in   = (req_cmd == CMD_APPEND) ? ST_IDLE : ST_PAD_MARK;
                  end else begin
                     state_in = (req_cmd == CMD_APPEND) ? ST_IDLE : ST_PAD_MARK;
                  end
               end else if (req_cmd == CMD_FINISH) begin
                  state_in = ST_PAD_MARK;
               end
            end
         end
         ST_PAD_MARK: begin
            dp_cmd.load_byte = 1'b1;
            dp_cmd.src       = SRC_MARK;
            if (dp_sts.pos_last) begin
               dp_cmd.round_load = 1'b1;
               round_in = '0;
               state_in = ST_ROUND;
               ret_in   = ST_PAD_ZERO;
            end else begin
               state_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_ZERO: begin
            if (dp_sts.pos_at_len) begin
               state_in = ST_PAD_LEN;
            end else begin
               dp_cmd.load_byte = 1'b1;
               dp_cmd.src       = SRC_ZERO;
               if (dp_sts.pos_last) begin
                  dp_cmd.round_load = 1'b1;
                  round_in = '0;
                  state_in = ST_ROUND;
                  ret_in   = ST_PAD_ZERO;
               end
            end
         end
         ST_PAD_LEN: begin
            dp_cmd.load_byte = 1'b1;
            dp_cmd.src       = SRC_LEN;
            if (dp_sts.pos_last) begin
               dp_cmd.round_load = 1'b1;
               round_in = '0;
               state_in = ST_ROUND;
               ret_in   = ST_OUTPUT;
            end
         end
         ST_ROUND: begin
            dp_cmd.round = 1'b1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FINAL;
            end else begin
               round_in = round_ff + 7'd1;
            end
         end
         ST_FINAL: begin
            dp_cmd.final_add = 1'b1;
            state_in = ret_ff;
         end
         ST_OUTPUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (idx_ff == LAST_WORD_IDX) begin
                  dp_cmd.restart = 1'b1;
                  idx_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/sha1_message_digest.sv -----
// sha1_message_digest: sha-1 engine over a byte stream, top level
// joins sha1md_ctrl and sha1md_datapath; depends on sha1md_pkg and sha1md_if
//
// usage: each request carries cmd and data_byte. cmd append stores a byte,
// append-finish stores a byte and closes the message, finish closes it with
// no byte; the unused code is accepted and dropped. one request at a time.
// the byte that completes a 64-byte block starts a compression (80 rounds
// on one shared round unit, then the chaining add); no request is taken
// meanwhile. on finish the block pads itself byte by byte (0x80, zeros,
// 64-bit length), running one or two compressions; the first response is
// valid once the last of them is done.
// then five responses carry the digest words, index 0 first, last_word set
// on index 4; one word per cycle while rsp ready is high.
// while the receiver stalls, the current word holds and no request is taken.
// after the fifth word the chaining value and bit count return to the
// initial values. reset (synchronous, active high) does the same and
// empties the partial block; requests are taken the cycle after reset.

module sha1_message_digest (
   input  logic         clock,
   input  logic         reset,
   sha1md_req_if.sink   req_chan,
   sha1md_rsp_if.source rsp_chan
);
   import sha1md_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_sts_type  dp_sts;
   logic [31:0] digest_word;

   sha1md_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_cmd    (dp_cmd),
      .dp_sts    (dp_sts)
   );

   sha1md_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_chan.data_byte),
      .dp_cmd      (dp_cmd),
      .dp_sts      (dp_sts),
      .digest_word (digest_word)
   );

   assign rsp_chan.digest_word = digest_word;
   assign rsp_chan.word_index  = dp_cmd.out_idx;
   assign rsp_chan.last_word   = (dp_cmd.out_idx == LAST_WORD_IDX);

endmodule
